// File: rtl/argb_pixel_blend_unit_assert.svh
// assertion macros shared by the blend unit checker
// depends on nothing; pulled in by files that assert
`ifndef ARGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`define ARGB_PIXEL_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ABP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blend unit check failed");

// next-cycle implication, disabled while reset is asserted
`define ABP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blend unit check failed");

`endif

// File: rtl/abp_pkg.sv
// types and constants for the argb pixel blend unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

  // blend mode codes
  localparam logic [2:0] MODE_REPLACE  = 3'd0;
  localparam logic [2:0] MODE_SUM_WRAP = 3'd1;
  localparam logic [2:0] MODE_SUM_SAT  = 3'd2;
  localparam logic [2:0] MODE_MULTIPLY = 3'd3;
  localparam logic [2:0] MODE_INTERP   = 3'd4;

  // fixed-point one for the mix fraction
  localparam logic [8:0] FRAC_ONE = 9'd256;

  // number of register stages in the datapath
  localparam int unsigned NUM_STAGES = 4;

  typedef struct packed {
    logic [7:0] dst_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] src_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [8:0] mix_fraction;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_pix_t;

  // stage enables and the mode that travels with the item into the last stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [2:0]            mode_s3;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/abp_pipe_ctrl.sv
// pipeline control: valid bits, stage enables, mode register and its pipeline copy
// depends on abp_pkg
`timescale 1ns / 1ps
`default_nettype none

module abp_pipe_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_data_i,
  output abp_pkg::pipe_ctrl_t     ctrl_o
);

  logic [abp_pkg::NUM_STAGES-1:0] valid_q, valid_d;
  logic [abp_pkg::NUM_STAGES-1:0] en;
  logic [2:0] mode_q, mode_d;
  logic [2:0] mode_s1_q, mode_s2_q, mode_s3_q;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[abp_pkg::NUM_STAGES-1] = !valid_q[abp_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = abp_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < abp_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  // mode register, written by a config transfer
  assign cfg_ready_o = 1'b1;
  assign mode_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mode_q  <= abp_pkg::MODE_REPLACE;
    end else begin
      valid_q <= valid_d;
      mode_q  <= mode_d;
    end
  end

  // mode copy carried alongside each item
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_s1_q <= mode_q;
    end
    if (en[1]) begin
      mode_s2_q <= mode_s1_q;
    end
    if (en[2]) begin
      mode_s3_q <= mode_s2_q;
    end
  end

  assign in_stall_o     = !en[0];
  assign out_valid_o    = valid_q[abp_pkg::NUM_STAGES-1];
  assign ctrl_o.en      = en;
  assign ctrl_o.mode_s3 = mode_s3_q;

endmodule

`default_nettype wire

// File: rtl/abp_lane.sv
// one color channel of the blend datapath, four register stages
// depends on abp_pkg
`timescale 1ns / 1ps
`default_nettype none

module abp_lane (
  input  wire logic                clk_i,
  input  wire abp_pkg::pipe_ctrl_t ctrl_i,
  input  wire logic                alpha_lane_i,
  input  wire logic [7:0]          a_i,
  input  wire logic [8:0]          f_i,
  input  wire logic [7:0]          d_i,
  input  wire logic [7:0]          s_i,
  output logic [7:0]               res_o
);

  // stage 1: the four partial products
  logic [15:0] as_d, as_q;
  logic [15:0] ad_d, ad_q;
  logic [16:0] sf_d, sf_q;
  logic [16:0] df_d, df_q;
  logic [7:0]  na_d, na_q;
  logic [7:0]  d1_q;

  // stage 2: sums
  logic [16:0] rep_d, rep2_q;
  logic [17:0] int_d, int2_q;
  logic [8:0]  add_d, add2_q;
  logic [16:0] mulw_d, mulw2_q;
  logic [7:0]  d2_q;

  // stage 3: multiply-mode product
  logic [24:0] mulp_d, mulp3_q;
  logic [16:0] rep3_q;
  logic [17:0] int3_q;
  logic [8:0]  add3_q;
  logic [7:0]  d3_q;

  // stage 4: selected result
  logic [7:0]  res_d, res_q;

  // products: a*s, (255-a)*d, s*f, d*(1-f)
  assign na_d = 8'd255 - a_i;
  assign as_d = 16'(a_i) * 16'(s_i);
  assign ad_d = 16'(na_d) * 16'(d_i);
  assign sf_d = 17'(s_i) * 17'(f_i);
  assign df_d = 17'(d_i) * 17'(abp_pkg::FRAC_ONE - f_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      as_q <= as_d;
      ad_q <= ad_d;
      sf_q <= sf_d;
      df_q <= df_d;
      na_q <= na_d;
      d1_q <= d_i;
    end
  end

  // replace and interpolate sums, sum-mode add, multiply-mode weight
  assign rep_d  = 17'(as_q) + 17'(ad_q);
  assign int_d  = 18'(sf_q) + 18'(df_q);
  assign add_d  = 9'(d1_q) + 9'(as_q[15:8]);
  assign mulw_d = 17'(as_q) + {1'b0, na_q, 8'h00};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      rep2_q  <= rep_d;
      int2_q  <= int_d;
      add2_q  <= add_d;
      mulw2_q <= mulw_d;
      d2_q    <= d1_q;
    end
  end

  // d * (a*s + (255-a)*256)
  assign mulp_d = 25'(d2_q) * 25'(mulw2_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      mulp3_q <= mulp_d;
      rep3_q  <= rep2_q;
      int3_q  <= int2_q;
      add3_q  <= add2_q;
      d3_q    <= d2_q;
    end
  end

  // pick the result for the item's mode; alpha passes through outside interpolate
  always_comb begin
    case (ctrl_i.mode_s3)
      abp_pkg::MODE_REPLACE:  res_d = rep3_q[15:8];
      abp_pkg::MODE_SUM_WRAP: res_d = add3_q[7:0];
      abp_pkg::MODE_SUM_SAT:  res_d = add3_q[8] ? 8'hFF : add3_q[7:0];
      abp_pkg::MODE_MULTIPLY: res_d = mulp3_q[23:16];
      abp_pkg::MODE_INTERP:   res_d = int3_q[15:8];
      default:                res_d = d3_q;
    endcase
    if (alpha_lane_i && (ctrl_i.mode_s3 != abp_pkg::MODE_INTERP)) begin
      res_d = d3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: rtl/argb_pixel_blend_unit.sv
// top level of the argb pixel blend unit: control plus four channel lanes
// depends on abp_pkg, abp_pipe_ctrl, abp_lane
//
// channel  | signals                          | direction | transfer when
// ---------+----------------------------------+-----------+-----------------------
// in       | in_valid_i, in_stall_o, in_data_i | sink      | valid high, stall low
// out      | out_valid_o, out_stall_i, out_data_o | source | valid high, stall low
// cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i | sink   | valid and ready high
//
// one pixel per clock while out_stall_i is low; four register stages from input to output
// the multiply mode's second product sets the stage count
// reset clears the valid bits and sets the mode to replace; ready for pixels right away
// out_stall_i holds the last stage; bubbles upstream still fill, then in_stall_o rises
// cfg_ready_o is always high
`timescale 1ns / 1ps
`default_nettype none

module argb_pixel_blend_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire abp_pkg::in_pix_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output abp_pkg::out_pix_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_data_i
);

  abp_pkg::pipe_ctrl_t ctrl;
  logic [8:0] frac_sat;

  // fractions above one act as one
  assign frac_sat = (in_data_i.mix_fraction > abp_pkg::FRAC_ONE) ? abp_pkg::FRAC_ONE
                                                                 : in_data_i.mix_fraction;

  abp_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl)
  );

  // alpha lane
  abp_lane u_lane_a (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .alpha_lane_i (1'b1),
    .a_i          (in_data_i.src_alpha),
    .f_i          (frac_sat),
    .d_i          (in_data_i.dst_alpha),
    .s_i          (in_data_i.src_alpha),
    .res_o        (out_data_o.out_alpha)
  );

  // red lane
  abp_lane u_lane_r (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .alpha_lane_i (1'b0),
    .a_i          (in_data_i.src_alpha),
    .f_i          (frac_sat),
    .d_i          (in_data_i.dst_red),
    .s_i          (in_data_i.src_red),
    .res_o        (out_data_o.out_red)
  );

  // green lane
  abp_lane u_lane_g (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .alpha_lane_i (1'b0),
    .a_i          (in_data_i.src_alpha),
    .f_i          (frac_sat),
    .d_i          (in_data_i.dst_green),
    .s_i          (in_data_i.src_green),
    .res_o        (out_data_o.out_green)
  );

  // blue lane
  abp_lane u_lane_b (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .alpha_lane_i (1'b0),
    .a_i          (in_data_i.src_alpha),
    .f_i          (frac_sat),
    .d_i          (in_data_i.dst_blue),
    .s_i          (in_data_i.src_blue),
    .res_o        (out_data_o.out_blue)
  );

endmodule

`default_nettype wire

// File: rtl/abp_chk.sv
// port-level checks for the argb pixel blend unit, bound to the top level
// depends on abp_pkg and argb_pixel_blend_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "argb_pixel_blend_unit_assert.svh"

module abp_chk (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_o,
  input  wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  input  wire abp_pkg::out_pix_t out_data_o
);

  logic       in_xfer;
  logic       run_clear;
  logic [3:0] xfer_hist_d, xfer_hist_q;

  assign in_xfer = in_valid_i && !in_stall_o;

  // input transfers shifted along while the output side keeps moving
  assign xfer_hist_d = {xfer_hist_q[2:0] & {3{!out_stall_i}}, in_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xfer_hist_q <= '0;
    end else begin
      xfer_hist_q <= xfer_hist_d;
    end
  end

  // input transfer that has reached the last history bit with reset high and no output stall since then
  assign run_clear = xfer_hist_q[3];

  // a held result stays valid and unchanged
  `ABP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ABP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // the input side only stalls when the whole pipe is backed up
  `ABP_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // with no output stall an accepted pixel shows as out_valid_o once through all four register stages
  `ABP_ASSERT_IMPL(a_latency, clk_i, rst_ni, run_clear, out_valid_o)

endmodule

bind argb_pixel_blend_unit abp_chk u_abp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
